// ----- src/lfpid_pkg.sv -----
`timescale 1ns / 1ps
package lfpid_pkg;

	localparam int SAMPLE_BITS_DEF = 10;

	localparam int THR_W   = 10;
	localparam int GAIN_W  = 14;
	localparam int LIM_W   = 20;
	localparam int TIME_W  = 32;
	localparam int CODE_W  = 3;
	localparam int PAT_W   = 3;
	localparam int ERR_W   = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int INTEG_W   = LIM_W + 1;
	localparam int SUM_W     = TIME_W + 4;
	localparam int DE_W      = ERR_W + 1;
	localparam int DIVD_W    = 34;
	localparam int DIVS_W    = TIME_W;
	localparam int DIV_STEPS = DIVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int CORR_W    = 28;
	localparam int KD_DE_W   = GAIN_W + DE_W;
	localparam int MILLI_W   = 10;
	localparam int STEP_W    = 4;

	// Division by a thousand is a shift by three followed by a multiplication
	// with the scaled reciprocal of 125, exact for every product that fits.
	localparam int RECIP_PRE    = 3;
	localparam int RECIP_IN_W   = DIVD_W - RECIP_PRE;
	localparam int RECIP_W      = 32;
	localparam int RECIP_SHIFT  = 38;
	localparam int RECIP_PROD_W = RECIP_IN_W + RECIP_W;
	localparam int RECIP_Q_W    = RECIP_PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;

	localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(512);
	localparam logic [GAIN_W-1:0] KP_RESET    = GAIN_W'(800);
	localparam logic [GAIN_W-1:0] KI_RESET    = GAIN_W'(0);
	localparam logic [GAIN_W-1:0] KD_RESET    = GAIN_W'(400);
	localparam logic [LIM_W-1:0]  LIM_RESET   = LIM_W'(50000);

	localparam logic [MILLI_W-1:0]       MILLI      = MILLI_W'(1000);
	localparam logic signed [CORR_W-1:0] CORR_LARGE = CORR_W'(1500);
	localparam logic signed [CORR_W-1:0] CORR_SMALL = CORR_W'(500);

	localparam logic [PAT_W-1:0] PAT_LEFT       = 3'b100;
	localparam logic [PAT_W-1:0] PAT_LEFT_MID   = 3'b110;
	localparam logic [PAT_W-1:0] PAT_MID_RIGHT  = 3'b011;
	localparam logic [PAT_W-1:0] PAT_RIGHT      = 3'b001;

	localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT   = 3'sd2;
	localparam logic signed [ERR_W-1:0] ERR_NEAR_LEFT  = 3'sd1;
	localparam logic signed [ERR_W-1:0] ERR_CENTRE     = 3'sd0;
	localparam logic signed [ERR_W-1:0] ERR_NEAR_RIGHT = -3'sd1;
	localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT  = -3'sd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_THR   = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_INTEG_GAIN  = 3'd2,
		REG_DERIV_GAIN  = 3'd3,
		REG_INTEG_LIMIT = 3'd4
	} cfg_reg_t;

	typedef enum logic [CODE_W-1:0] {
		STEER_NONE        = 3'd0,
		STEER_SMALL_LEFT  = 3'd1,
		STEER_LARGE_LEFT  = 3'd2,
		STEER_SMALL_RIGHT = 3'd3,
		STEER_LARGE_RIGHT = 3'd4
	} steer_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_INTEG,
		OP_CLAMP,
		OP_IMUL,
		OP_RECIP,
		OP_DIV,
		OP_ADDQ,
		OP_DMUL1,
		OP_DMUL2,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_DIV_BUSY,
		C_OUT_FREE
	} cond_t;

	localparam logic [STEP_W-1:0] ST_WAIT  = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_DIV_D = STEP_W'(8);
	localparam logic [STEP_W-1:0] ST_EMIT  = STEP_W'(10);

	typedef struct packed {
		logic               accept;
		op_t                op;
		cond_t              cond;
		logic [STEP_W-1:0]  target;
	} ucode_t;

	typedef struct packed {
		logic div_busy;
		logic out_full;
	} dp_status_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_rom = '{1'b0, OP_NOP, C_ALWAYS, ST_WAIT};
		unique case (step)
			4'd0:  ucode_rom = '{1'b1, OP_LOAD,  C_NO_INPUT, ST_WAIT};
			4'd1:  ucode_rom = '{1'b0, OP_INTEG, C_NEVER,    ST_WAIT};
			4'd2:  ucode_rom = '{1'b0, OP_CLAMP, C_NEVER,    ST_WAIT};
			4'd3:  ucode_rom = '{1'b0, OP_IMUL,  C_NEVER,    ST_WAIT};
			4'd4:  ucode_rom = '{1'b0, OP_RECIP, C_NEVER,    ST_WAIT};
			4'd5:  ucode_rom = '{1'b0, OP_ADDQ,  C_NEVER,    ST_WAIT};
			4'd6:  ucode_rom = '{1'b0, OP_DMUL1, C_NEVER,    ST_WAIT};
			4'd7:  ucode_rom = '{1'b0, OP_DMUL2, C_NEVER,    ST_WAIT};
			4'd8:  ucode_rom = '{1'b0, OP_DIV,   C_DIV_BUSY, ST_DIV_D};
			4'd9:  ucode_rom = '{1'b0, OP_ADDQ,  C_NEVER,    ST_WAIT};
			4'd10: ucode_rom = '{1'b0, OP_EMIT,  C_OUT_FREE, ST_WAIT};
			4'd11: ucode_rom = '{1'b0, OP_NOP,   C_ALWAYS,   ST_EMIT};
			default: ucode_rom = '{1'b0, OP_NOP, C_ALWAYS, ST_WAIT};
		endcase
	endfunction

	function automatic logic signed [ERR_W-1:0] pattern_error(input logic [PAT_W-1:0] pat);
		pattern_error = ERR_CENTRE;
		unique case (pat)
			PAT_LEFT:      pattern_error = ERR_FAR_LEFT;
			PAT_LEFT_MID:  pattern_error = ERR_NEAR_LEFT;
			PAT_MID_RIGHT: pattern_error = ERR_NEAR_RIGHT;
			PAT_RIGHT:     pattern_error = ERR_FAR_RIGHT;
			default:       pattern_error = ERR_CENTRE;
		endcase
	endfunction

endpackage

// ----- src/lfpid_in_if.sv -----
`timescale 1ns / 1ps
interface lfpid_in_if import lfpid_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_sample;
	logic [SAMPLE_BITS-1:0] middle_sample;
	logic [SAMPLE_BITS-1:0] right_sample;
	logic [TIME_W-1:0]      now_ms;

	modport source (output valid, left_sample, middle_sample, right_sample, now_ms,
		input ready);
	modport sink (input valid, left_sample, middle_sample, right_sample, now_ms,
		output ready);
endinterface

// ----- src/lfpid_out_if.sv -----
`timescale 1ns / 1ps
interface lfpid_out_if import lfpid_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CODE_W-1:0]       steer_code;
	logic [PAT_W-1:0]        sensor_pattern;
	logic signed [ERR_W-1:0] line_error;

	modport source (output valid, steer_code, sensor_pattern, line_error, input ready);
	modport sink (input valid, steer_code, sensor_pattern, line_error, output ready);
endinterface

// ----- src/line_follow_pid_steering.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// sense     in         left_sample, middle_sample, right_sample, now_ms
// steer     out        steer_code, sensor_pattern, line_error
// cfg       in         cfg_wr_en, cfg_idx, cfg_data (write only)
//
// A result is offered at the emit step of the microprogram; the next item is
// taken only after that. Most of the work is done by the restoring divider
// for the derivative term at one quotient bit per cycle; the integral term is
// divided by a thousand by a reciprocal multiplication instead.
// A new item is taken once the microprogram returns to its wait step.
// The result sits in an output register, so the next item is accepted while
// it waits; the program loops on its emit step only if the previous result
// has not yet been taken. Reset restores the register defaults and clears the
// timestamp, previous error and integral; no clearing pass is needed.
module line_follow_pid_steering import lfpid_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	lfpid_in_if.sink             sense,
	lfpid_out_if.source          steer,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	ucode_t     cw;
	dp_status_t status;
	logic       in_fire;

	assign sense.ready = cw.accept;
	assign in_fire     = sense.valid && cw.accept;

	lfpid_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sense.valid),
		.status   (status),
		.cw       (cw)
	);

	lfpid_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cw             (cw),
		.status         (status),
		.in_fire        (in_fire),
		.left_sample    (sense.left_sample),
		.middle_sample  (sense.middle_sample),
		.right_sample   (sense.right_sample),
		.now_ms         (sense.now_ms),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.out_valid      (steer.valid),
		.out_ready      (steer.ready),
		.steer_code     (steer.steer_code),
		.sensor_pattern (steer.sensor_pattern),
		.line_error     (steer.line_error)
	);
endmodule

// ----- src/lfpid_useq.sv -----
`timescale 1ns / 1ps
module lfpid_useq import lfpid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output ucode_t     cw
);
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		cw   = ucode_rom(step_q);
		take = 1'b0;
		unique case (cw.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = !in_valid;
			C_DIV_BUSY: take = status.div_busy;
			C_OUT_FREE: take = !status.out_full;
			default:    take = 1'b0;
		endcase
		step_d = take ? cw.target : step_q + STEP_W'(1);
	end
endmodule

// ----- src/lfpid_dpath.sv -----
`timescale 1ns / 1ps
module lfpid_dpath import lfpid_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ucode_t                  cw,
	output dp_status_t              status,
	input  logic                    in_fire,
	input  logic [SAMPLE_BITS-1:0]  left_sample,
	input  logic [SAMPLE_BITS-1:0]  middle_sample,
	input  logic [SAMPLE_BITS-1:0]  right_sample,
	input  logic [TIME_W-1:0]       now_ms,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CODE_W-1:0]       steer_code,
	output logic [PAT_W-1:0]        sensor_pattern,
	output logic signed [ERR_W-1:0] line_error
);
	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [THR_W-1:0]  thr_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;
	logic [LIM_W-1:0]  lim_q;

	logic [TIME_W-1:0]        prev_time_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;

	logic [PAT_W-1:0]          pat_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [TIME_W-1:0]         dt_q;
	logic signed [DE_W-1:0]    de_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [CORR_W-1:0]  corr_q;
	logic [DIVD_W-1:0]         quo_q;
	logic [DIVS_W-1:0]         rem_q;
	logic [DIVS_W-1:0]         divs_q;
	logic                      neg_q;
	logic [CODE_W-1:0]         code_out_q;
	logic [PAT_W-1:0]          pat_out_q;
	logic signed [ERR_W-1:0]   err_out_q;

	logic [PAT_W-1:0]          pat_in;
	logic signed [ERR_W-1:0]   err_in;
	logic [TIME_W-1:0]         diff;
	logic [TIME_W-1:0]         dt_in;
	logic signed [DE_W-1:0]    de_in;
	logic [ERR_W-1:0]          e_abs;
	logic [SUM_W-1:0]          term_mag;
	logic signed [SUM_W-1:0]   term;
	logic signed [SUM_W-1:0]   integ_ext;
	logic signed [SUM_W-1:0]   lim_pos;
	logic signed [SUM_W-1:0]   lim_neg;
	logic [INTEG_W-1:0]        i_abs;
	logic [GAIN_W+INTEG_W-1:0] i_prod;
	logic [RECIP_PROD_W-1:0]   recip_prod;
	logic [CORR_W-1:0]         p_mag;
	logic signed [CORR_W-1:0]  p_term;
	logic [DE_W-1:0]           de_abs;
	logic [KD_DE_W-1:0]        kd_prod;
	logic [KD_DE_W+MILLI_W-1:0] d_prod;
	logic [DIVS_W:0]           shifted;
	logic [DIVS_W:0]           trial;
	logic                      ge;
	logic signed [CORR_W-1:0]  q_mag;
	logic signed [CORR_W-1:0]  q_signed;
	logic [CODE_W-1:0]         code_d;
	logic                      emit;

	always_comb begin
		pat_in = {CMP_W'(left_sample) >= CMP_W'(thr_q),
			CMP_W'(middle_sample) >= CMP_W'(thr_q),
			CMP_W'(right_sample) >= CMP_W'(thr_q)};
		err_in = pattern_error(pat_in);
		diff   = now_ms - prev_time_q;
		dt_in  = (diff == '0) ? TIME_W'(1) : diff;
		de_in  = {err_in[ERR_W-1], err_in} - {prev_err_q[ERR_W-1], prev_err_q};

		e_abs    = err_q[ERR_W-1] ? -err_q : err_q;
		term_mag = e_abs[1] ? {SUM_W'(dt_q) << 1} : (e_abs[0] ? SUM_W'(dt_q) : '0);
		term     = err_q[ERR_W-1] ? -$signed(term_mag) : $signed(term_mag);
		integ_ext = {{(SUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
		lim_pos  = $signed({{(SUM_W-LIM_W){1'b0}}, lim_q});
		lim_neg  = -lim_pos;

		i_abs  = integ_q[INTEG_W-1] ? -integ_q : integ_q;
		i_prod = ki_q * i_abs;
		recip_prod = quo_q[DIVD_W-1:RECIP_PRE] * RECIP_125;
		p_mag  = e_abs[1] ? {CORR_W'(kp_q) << 1} : (e_abs[0] ? CORR_W'(kp_q) : '0);
		p_term = err_q[ERR_W-1] ? -$signed(p_mag) : $signed(p_mag);

		de_abs  = de_q[DE_W-1] ? -de_q : de_q;
		kd_prod = kd_q * de_abs;
		d_prod  = quo_q[KD_DE_W-1:0] * MILLI;

		shifted = {rem_q, quo_q[DIVD_W-1]};
		trial   = shifted - {1'b0, divs_q};
		ge      = shifted >= {1'b0, divs_q};

		q_mag    = $signed({1'b0, quo_q[CORR_W-2:0]});
		q_signed = neg_q ? -q_mag : q_mag;

		if (corr_q > CORR_LARGE) begin
			code_d = STEER_LARGE_LEFT;
		end else if (corr_q > CORR_SMALL) begin
			code_d = STEER_SMALL_LEFT;
		end else if (corr_q < -CORR_LARGE) begin
			code_d = STEER_LARGE_RIGHT;
		end else if (corr_q < -CORR_SMALL) begin
			code_d = STEER_SMALL_RIGHT;
		end else begin
			code_d = STEER_NONE;
		end

		emit = (cw.op == OP_EMIT) && !out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			kp_q        <= KP_RESET;
			ki_q        <= KI_RESET;
			kd_q        <= KD_RESET;
			lim_q       <= LIM_RESET;
			prev_time_q <= '0;
			prev_err_q  <= '0;
			integ_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_idx)
					REG_WHITE_THR:   thr_q <= cfg_data[THR_W-1:0];
					REG_PROP_GAIN:   kp_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN:  ki_q  <= cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN:  kd_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEG_LIMIT: lim_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				prev_time_q <= now_ms;
				prev_err_q  <= err_in;
			end
			if (cw.op == OP_CLAMP) begin
				if (sum_q > lim_pos) begin
					integ_q <= lim_pos[INTEG_W-1:0];
				end else if (sum_q < lim_neg) begin
					integ_q <= lim_neg[INTEG_W-1:0];
				end else begin
					integ_q <= sum_q[INTEG_W-1:0];
				end
			end
			case (cw.op)
				OP_DMUL2: cnt_q <= CNT_W'(DIV_STEPS - 1);
				OP_DIV:   cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end else if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pat_q <= pat_in;
			err_q <= err_in;
			dt_q  <= dt_in;
			de_q  <= de_in;
		end
		case (cw.op)
			OP_INTEG: sum_q <= integ_ext + term;
			OP_IMUL: begin
				quo_q  <= i_prod[DIVD_W-1:0];
				neg_q  <= integ_q[INTEG_W-1];
				corr_q <= p_term;
			end
			OP_RECIP: begin
				quo_q <= {{(DIVD_W-RECIP_Q_W){1'b0}},
					recip_prod[RECIP_PROD_W-1:RECIP_SHIFT]};
			end
			OP_DIV: begin
				rem_q <= ge ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], ge};
			end
			OP_ADDQ: corr_q <= corr_q + q_signed;
			OP_DMUL1: begin
				quo_q <= DIVD_W'(kd_prod);
				neg_q <= de_q[DE_W-1];
			end
			OP_DMUL2: begin
				quo_q  <= DIVD_W'(d_prod);
				divs_q <= dt_q;
				rem_q  <= '0;
			end
			default: ;
		endcase
		if (emit) begin
			code_out_q <= code_d;
			pat_out_q  <= pat_q;
			err_out_q  <= err_q;
		end
	end

	assign status.div_busy = (cnt_q != '0);
	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign steer_code      = code_out_q;
	assign sensor_pattern  = pat_out_q;
	assign line_error      = err_out_q;
endmodule
